>>> rtl/lhcg_pkg.sv
// Package: shared types and constants for the line height color gradient block.
package lhcg_pkg;

  localparam int CoordW = 16;
  localparam int MaxHW  = 15;
  localparam int ColorW = 24;
  localparam int CfgW   = 24;
  localparam int IdxW   = 3;
  localparam int NumReg = 6;

  localparam logic [IdxW-1:0] RegMaxHeight = 3'd0;
  localparam logic [IdxW-1:0] RegPal0      = 3'd1;
  localparam logic [IdxW-1:0] RegPal1      = 3'd2;
  localparam logic [IdxW-1:0] RegPal2      = 3'd3;
  localparam logic [IdxW-1:0] RegPal3      = 3'd4;
  localparam logic [IdxW-1:0] RegPal4      = 3'd5;

  localparam logic [MaxHW-1:0]  MaxHeightRst = 15'd1;
  localparam logic [ColorW-1:0] Pal0Rst = 24'h4400ff;
  localparam logic [ColorW-1:0] Pal1Rst = 24'h17571a;
  localparam logic [ColorW-1:0] Pal2Rst = 24'h3651ff;
  localparam logic [ColorW-1:0] Pal3Rst = 24'hff0000;
  localparam logic [ColorW-1:0] Pal4Rst = 24'hff1fff;

  typedef struct packed {
    logic signed [CoordW-1:0] pixel_x;
    logic signed [CoordW-1:0] pixel_y;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_height;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_height;
  } req_t;

  typedef struct packed {
    logic [ColorW-1:0] pixel_color;
    logic              height_clamped;
  } rsp_t;

endpackage

>>> rtl/lhcg_div_cell.sv
// One restoring-division step cell: one quotient bit per cycle, passes its work on.
module lhcg_div_cell import lhcg_pkg::*; #(
  parameter int NumW = 48,
  parameter int DenW = 32,
  parameter int TagW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  logic [DenW:0]   in_rem,
  input  logic [NumW-1:0] in_num,
  input  logic [DenW-1:0] in_den,
  input  logic [TagW-1:0] in_tag,
  output logic            out_vld,
  output logic [DenW:0]   out_rem,
  output logic [NumW-1:0] out_num,
  output logic [DenW-1:0] out_den,
  output logic [TagW-1:0] out_tag
);

  logic [DenW+1:0] trial;
  logic [DenW+1:0] shifted;

  // shift in the next numerator bit, subtract if it fits; quotient bit lands in num LSB
  always_comb begin
    shifted = {in_rem, in_num[NumW-1]};
    trial   = shifted - {2'b00, in_den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (trial[DenW+1]) begin
      out_rem <= shifted[DenW:0];
      out_num <= {in_num[NumW-2:0], 1'b0};
    end else begin
      out_rem <= trial[DenW:0];
      out_num <= {in_num[NumW-2:0], 1'b1};
    end
    out_den <= in_den;
    out_tag <= in_tag;
  end

endmodule

>>> rtl/lhcg_divider.sv
// Pipelined divider built from a row of step cells, quotient of NumW bits.
module lhcg_divider import lhcg_pkg::*; #(
  parameter int NumW = 48,
  parameter int DenW = 32,
  parameter int TagW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  logic [NumW-1:0] in_num,
  input  logic [DenW-1:0] in_den,
  input  logic [TagW-1:0] in_tag,
  output logic            out_vld,
  output logic [NumW-1:0] out_quo,
  output logic [TagW-1:0] out_tag
);

  logic            vld [NumW+1];
  logic [DenW:0]   rem [NumW+1];
  logic [NumW-1:0] num [NumW+1];
  logic [DenW-1:0] den [NumW+1];
  logic [TagW-1:0] tag [NumW+1];

  assign vld[0] = in_vld;
  assign rem[0] = '0;
  assign num[0] = in_num;
  assign den[0] = in_den;
  assign tag[0] = in_tag;

  for (genvar i = 0; i < NumW; i++) begin : g_cell
    lhcg_div_cell #(.NumW(NumW), .DenW(DenW), .TagW(TagW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (vld[i]),
      .in_rem  (rem[i]),
      .in_num  (num[i]),
      .in_den  (den[i]),
      .in_tag  (tag[i]),
      .out_vld (vld[i+1]),
      .out_rem (rem[i+1]),
      .out_num (num[i+1]),
      .out_den (den[i+1]),
      .out_tag (tag[i+1])
    );
  end

  assign out_vld = vld[NumW];
  assign out_quo = num[NumW];
  assign out_tag = tag[NumW];

endmodule

>>> rtl/line_height_color_gradient.sv
// Top level: line height color gradient, progress divider, height scaler and blender.
//
//  channel  | handshake         | payload
//  request  | start / busy      | req  (req_t)
//  result   | done strobe       | rsp  (rsp_t)
//  config   | cfg_we            | cfg_idx, cfg_data
//
// One request per cycle; busy is always low. done rises once a request has passed
// the input register, FRACTION_BITS+17 progress cells, the multiply and magnitude
// registers, FRACTION_BITS+21 scale cells and the blend and output registers. Reset
// clears valid bits and restores the registers. The receiver cannot stall; done
// pulses for one cycle per request in request order.
module line_height_color_gradient import lhcg_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  req_t            req,
  output logic            done,
  output rsp_t            rsp,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_idx,
  input  logic [CfgW-1:0] cfg_data
);

  localparam int F     = FRACTION_BITS;
  localparam int DW    = CoordW + 1;          // coordinate distance width
  localparam int PNumW = DW + F;              // progress dividend
  localparam int PW    = F + 1;               // progress 0..1
  localparam int ZW    = CoordW + F + 3;      // signed z width
  localparam int MW    = ZW;                  // magnitude width (unsigned)
  localparam int SNumW = MW + 2;              // mag*4
  localparam int TagW1 = 3 * CoordW;          // sh, dh(17), zero flag carried with progress
  localparam int TagW2 = 1;

  logic [MaxHW-1:0]  max_height;
  logic [ColorW-1:0] pal [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_height <= MaxHeightRst;
      pal[0] <= Pal0Rst;
      pal[1] <= Pal1Rst;
      pal[2] <= Pal2Rst;
      pal[3] <= Pal3Rst;
      pal[4] <= Pal4Rst;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegMaxHeight: max_height <= cfg_data[MaxHW-1:0];
        RegPal0:      pal[0] <= cfg_data;
        RegPal1:      pal[1] <= cfg_data;
        RegPal2:      pal[2] <= cfg_data;
        RegPal3:      pal[3] <= cfg_data;
        RegPal4:      pal[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [MaxHW-1:0] mh;
  assign mh = (max_height == '0) ? MaxHW'(1) : max_height;

  // stage 0: distances
  logic signed [DW-1:0] dxq_s, dyq_s, dxl_s, dyl_s;
  logic [DW-1:0] dxq, dyq, dxl, dyl;
  always_comb begin
    dxq_s = DW'(req.start_x) - DW'(req.pixel_x);
    dyq_s = DW'(req.start_y) - DW'(req.pixel_y);
    dxl_s = DW'(req.end_x) - DW'(req.start_x);
    dyl_s = DW'(req.end_y) - DW'(req.start_y);
    dxq = dxq_s[DW-1] ? DW'(-dxq_s) : DW'(dxq_s);
    dyq = dyq_s[DW-1] ? DW'(-dyq_s) : DW'(dyq_s);
    dxl = dxl_s[DW-1] ? DW'(-dxl_s) : DW'(dxl_s);
    dyl = dyl_s[DW-1] ? DW'(-dyl_s) : DW'(dyl_s);
  end

  logic              s1_vld;
  logic [DW-1:0]     s1_num, s1_den;
  logic signed [CoordW-1:0] s1_sh;
  logic signed [CoordW:0]   s1_dh;
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= start;
  end
  always_ff @(posedge clk) begin
    if (dxl > dyl) begin
      s1_num <= dxq; s1_den <= dxl;
    end else begin
      s1_num <= dyq; s1_den <= dyl;
    end
    s1_sh <= req.start_height;
    s1_dh <= (CoordW+1)'(req.end_height) - (CoordW+1)'(req.start_height);
  end

  // progress divider; zero denominator forces zero afterwards
  logic [TagW1-1:0] t1_in, t1_out;
  logic             d1_vld;
  logic [PNumW-1:0] d1_quo;
  logic [DW-1:0]    den_nz;
  assign den_nz = (s1_den == '0) ? DW'(1) : s1_den;
  assign t1_in  = {s1_sh, s1_dh, (CoordW-2)'(0), s1_den == '0};

  lhcg_divider #(.NumW(PNumW), .DenW(DW), .TagW(TagW1)) u_prog (
    .clk (clk), .rst (rst),
    .in_vld (s1_vld), .in_num ({s1_num, F'(0)}), .in_den (den_nz), .in_tag (t1_in),
    .out_vld (d1_vld), .out_quo (d1_quo), .out_tag (t1_out)
  );

  logic signed [CoordW-1:0] d1_sh;
  logic signed [CoordW:0]   d1_dh;
  logic                     d1_zero;
  logic [PW-1:0]            prog;
  assign d1_sh   = t1_out[TagW1-1 -: CoordW];
  assign d1_dh   = t1_out[TagW1-CoordW-1 -: CoordW+1];
  assign d1_zero = t1_out[0];
  assign prog = d1_zero ? '0 :
                (d1_quo > PNumW'(1 << F)) ? PW'(1 << F) : PW'(d1_quo);

  // stage: multiply dh*prog
  logic                  s2_vld;
  logic signed [ZW-1:0]  s2_prod, s2_base;
  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= d1_vld;
  end
  always_ff @(posedge clk) begin
    s2_prod <= ZW'(d1_dh * $signed({1'b0, prog}));
    s2_base <= ZW'(d1_sh) <<< F;
  end

  // stage: z, magnitude, clamp compare
  logic signed [ZW-1:0] z;
  logic [MW-1:0]        mag;
  assign z   = s2_base + s2_prod;
  assign mag = z[ZW-1] ? MW'(-z) : MW'(z);

  logic             s3_vld, s3_clamp;
  logic [MW-1:0]    s3_mag;
  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else     s3_vld <= s2_vld;
  end
  always_ff @(posedge clk) begin
    s3_mag   <= mag;
    s3_clamp <= mag >= (MW'(mh) << F);
  end

  // scale divider: s = mag*4 / mh
  logic             d2_vld;
  logic [SNumW-1:0] d2_quo;
  logic [TagW2-1:0] t2_out;
  lhcg_divider #(.NumW(SNumW), .DenW(MaxHW), .TagW(TagW2)) u_scale (
    .clk (clk), .rst (rst),
    .in_vld (s3_vld), .in_num ({s3_mag, 2'b00}), .in_den (mh), .in_tag (s3_clamp),
    .out_vld (d2_vld), .out_quo (d2_quo), .out_tag (t2_out)
  );

  logic [1:0]   idx;
  logic [F-1:0] frac;
  assign idx  = d2_quo[F +: 2];
  assign frac = d2_quo[F-1:0];

  logic [ColorW-1:0] ca, cb;
  always_comb begin
    case (idx)
      2'd0: begin ca = pal[0]; cb = pal[1]; end
      2'd1: begin ca = pal[1]; cb = pal[2]; end
      2'd2: begin ca = pal[2]; cb = pal[3]; end
      2'd3: begin ca = pal[3]; cb = pal[4]; end
      default: begin ca = pal[0]; cb = pal[1]; end
    endcase
  end

  // stage: channel products
  logic                   s4_vld, s4_clamp;
  logic signed [F+9:0]    s4_prod [3];
  logic [7:0]             s4_base [3];
  logic [ColorW-1:0]      s4_top;
  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else     s4_vld <= d2_vld;
  end
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      s4_base[c] <= ca[8*c +: 8];
      s4_prod[c] <= (F+10)'(($signed({1'b0, cb[8*c +: 8]}) - $signed({1'b0, ca[8*c +: 8]}))
                    * $signed({1'b0, frac}));
    end
    s4_clamp <= t2_out[0];
    s4_top   <= pal[4];
  end

  logic [ColorW-1:0] blend;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [F+9:0] acc;
      acc = ((F+10)'(s4_base[c]) <<< F) + s4_prod[c];
      blend[8*c +: 8] = acc[F +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= s4_vld;
  end
  always_ff @(posedge clk) begin
    rsp.pixel_color    <= s4_clamp ? s4_top : blend;
    rsp.height_clamped <= s4_clamp;
  end

`ifndef ASSERT_OFF
  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk) disable iff (rst) done |-> $past(s4_vld))
    else $error("done without pipeline valid");
  a_clamp_top: assert property (@(posedge clk) disable iff (rst)
    s4_vld && s4_clamp |=> rsp.pixel_color == $past(pal[4]))
    else $error("clamped color mismatch");
`endif

endmodule

>>> tb/sv/tb.sv
// Testbench for line_height_color_gradient: randomized requests checked against a predictor.
module tb import lhcg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 16;
  localparam int Latency  = 2 * FracBits + 42;
  localparam int CycleLimit = 400000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  req_t            req = '0;
  logic            done;
  rsp_t            rsp;
  logic            cfg_we = 1'b0;
  logic [IdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;

  line_height_color_gradient #(.FRACTION_BITS(FracBits)) DUT (
    .clk, .rst, .start, .busy, .req, .done, .rsp, .cfg_we, .cfg_idx, .cfg_data
  );

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic [MaxHW-1:0]  mh_reg;
  logic [ColorW-1:0] pal [5];

  req_t pending_reqs [$];
  rsp_t expected_colors [$];
  int   mismatches = 0;
  int   checked = 0;
  int   cycles = 0;
  int   gap_left = 0;
  int   clamp_seen = 0;

  function automatic logic [7:0] blend(logic [7:0] c0, logic [7:0] c1, logic [63:0] fr);
    longint acc;
    acc = longint'(c0) * (64'sd1 <<< FracBits) + (longint'(c1) - longint'(c0)) * longint'(fr);
    return 8'(acc >>> FracBits);
  endfunction

  function automatic rsp_t color_for(req_t r);
    longint dxq, dyq, dxl, dyl, num, den, prog, z, mh;
    longint unsigned mag, s, idx, fr;
    logic [ColorW-1:0] a, b;
    rsp_t o;
    dxq = longint'(r.start_x) - longint'(r.pixel_x); if (dxq < 0) dxq = -dxq;
    dyq = longint'(r.start_y) - longint'(r.pixel_y); if (dyq < 0) dyq = -dyq;
    dxl = longint'(r.end_x) - longint'(r.start_x);   if (dxl < 0) dxl = -dxl;
    dyl = longint'(r.end_y) - longint'(r.start_y);   if (dyl < 0) dyl = -dyl;
    num = 0; den = 0; prog = 0;
    if (dxl > dyl) begin
      num = dxq; den = dxl;
    end else if (dyl != 0) begin
      num = dyq; den = dyl;
    end
    if (den != 0) begin
      prog = (num << FracBits) / den;
      if (prog > (64'sd1 << FracBits)) prog = 64'sd1 << FracBits;
    end
    z = longint'(r.start_height) * (64'sd1 << FracBits)
      + (longint'(r.end_height) - longint'(r.start_height)) * prog;
    mag = (z < 0) ? -z : z;
    mh = (mh_reg == 0) ? 1 : mh_reg;
    if (mag >= (mh << FracBits)) begin
      o.pixel_color = pal[4];
      o.height_clamped = 1'b1;
    end else begin
      s = (mag * 4) / mh;
      idx = (s >> FracBits) & 3;
      fr = s & ((64'd1 << FracBits) - 1);
      a = pal[idx]; b = pal[idx + 1];
      o.pixel_color = {blend(a[23:16], b[23:16], fr), blend(a[15:8], b[15:8], fr),
                       blend(a[7:0], b[7:0], fr)};
      o.height_clamped = 1'b0;
    end
    return o;
  endfunction

  task automatic report(string what, rsp_t got, rsp_t want);
    mismatches++;
    $display("ERROR %0s: got color %h clamp %b, expected color %h clamp %b",
             what, got.pixel_color, got.height_clamped, want.pixel_color,
             want.height_clamped);
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) begin
        expected_colors.push_back(color_for(req));
        pending_reqs.pop_front();
      end
      // after the pop, the head of the queue is the next request to send
      if (start && !busy && gap_left == 0 && pending_reqs.size() > 0) begin
        req <= pending_reqs[0];
        gap_left <= $urandom_range(0, 9) * ($urandom_range(0, 3) == 0 ? 0 : 1);
      end else if (start && !busy) begin
        start <= 1'b0;
        if (gap_left == 0) gap_left <= $urandom_range(0, 9);
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        start <= 1'b1;
        req <= pending_reqs[0];
        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_colors.size() == 0) begin
        report("unexpected result", rsp, rsp);
      end else begin
        if (rsp.pixel_color !== expected_colors[0].pixel_color)
          report("pixel_color", rsp, expected_colors[0]);
        else if (rsp.height_clamped !== expected_colors[0].height_clamped)
          report("height_clamped", rsp, expected_colors[0]);
        if (expected_colors[0].height_clamped) clamp_seen++;
        checked++;
        expected_colors.pop_front();
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegMaxHeight) mh_reg = val[MaxHW-1:0];
    else pal[idx - RegPal0] = val[ColorW-1:0];
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_colors.size() == 0);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] edge_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // random line segment with a pixel near it; heights scaled around max_height
  function automatic req_t line_req(int span);
    req_t r;
    int hs;
    hs = (mh_reg == 0) ? 2 : int'(mh_reg) * 2 + 1;
    if (hs > 32767) hs = 32767;
    r.start_x = 16'($urandom_range(0, 2 * span) - span);
    r.start_y = 16'($urandom_range(0, 2 * span) - span);
    r.end_x = 16'(int'(r.start_x) + $urandom_range(0, 2 * span) - span);
    r.end_y = 16'(int'(r.start_y) + $urandom_range(0, 2 * span) - span);
    r.pixel_x = 16'(int'(r.start_x) + $urandom_range(0, 2 * span) - span);
    r.pixel_y = 16'(int'(r.start_y) + $urandom_range(0, 2 * span) - span);
    r.start_height = 16'($urandom_range(0, 2 * hs) - hs);
    r.end_height = 16'($urandom_range(0, 2 * hs) - hs);
    return r;
  endfunction

  function automatic req_t noise_req();
    req_t r;
    r = {edge_val(), edge_val(), edge_val(), edge_val(),
         edge_val(), edge_val(), edge_val(), edge_val()};
    return r;
  endfunction

  initial begin
    req_t r;
    mh_reg = MaxHeightRst;
    pal[0] = Pal0Rst; pal[1] = Pal1Rst; pal[2] = Pal2Rst;
    pal[3] = Pal3Rst; pal[4] = Pal4Rst;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, degenerate lines, extremes, beyond-end pixel
    r = '0; pending_reqs.push_back(r);
    r = '1; pending_reqs.push_back(r);
    r = {8{16'h8000}}; pending_reqs.push_back(r);
    r = {8{16'h7fff}}; pending_reqs.push_back(r);
    drain();
    write_reg(RegMaxHeight, 24'd1000);
    // x-dominant, y-dominant, beyond end, degenerate, negative heights
    pending_reqs.push_back('{16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd3, 16'sd999});
    pending_reqs.push_back('{16'sd0, 16'sd7, 16'sd0, 16'sd0, -16'sd100, 16'sd2, 16'sd10, -16'sd900});
    pending_reqs.push_back('{16'sd40, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd999});
    pending_reqs.push_back('{16'sd9, 16'sd9, 16'sd1, 16'sd1, 16'sd500, 16'sd1, 16'sd1, 16'sd0});
    pending_reqs.push_back('{16'sd3, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd6, 16'sd6, -16'sd1000});
    pending_reqs.push_back('{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 16'sd0,
                             -16'sd32768, 16'sd0, 16'sd32767});
    pending_reqs.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd999, 16'sd4, 16'sd0, 16'sd1000});
    for (int h = 0; h <= 1000; h += 125)
      pending_reqs.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'(h), 16'sd0, 16'sd0, 16'sd0});
    drain();

    // phases: several register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_reg(RegMaxHeight, 24'd0);
        1: write_reg(RegMaxHeight, 24'd32767);
        2: write_reg(RegMaxHeight, 24'hffffff);
        default: write_reg(RegMaxHeight, 24'($urandom_range(1, 4000)));
      endcase
      for (int k = 0; k < 5; k++)
        write_reg(IdxW'(RegPal0 + k), ph == 1 ? 24'h000000 : ph == 2 ? 24'hffffff :
                  ph == 3 ? (k[0] ? 24'hffffff : 24'h000000) : 24'($urandom));
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(0, 9) < 8)
          pending_reqs.push_back(line_req($urandom_range(0, 3) == 0 ? 30000 : 64));
        else
          pending_reqs.push_back(noise_req());
      end
      drain();
    end

    $display("Checked %0d results over 10 register settings, %0d clamped heights",
             checked, clamp_seen);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

>>> sim.f
rtl/lhcg_pkg.sv
rtl/lhcg_div_cell.sv
rtl/lhcg_divider.sv
rtl/line_height_color_gradient.sv
tb/sv/tb.sv
